// ===== rtl/i2c_bitbang_master_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// I2C bit-bang sequencer assertion macros
// Shared concurrent assertion forms; clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_BITBANG_MASTER_SEQUENCER_DEFINES_SVH
`define I2C_BITBANG_MASTER_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define I2CBB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cbb assertion failed");

// next-cycle implication
`define I2CBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cbb assertion failed");

`endif

// ===== rtl/i2cbb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types and timing constants of the I2C bit-bang sequencer.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

    localparam logic [2:0] T_LONG        = 3'd4;
    localparam logic [2:0] T_HALF        = 3'd2;
    localparam logic [2:0] T_SAMPLE      = 3'd1;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [7:0] POLL_RESET    = 8'd250;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_WAIT  = 3'd4,
        OP_READ  = 3'd5,
        OP_ACK   = 3'd6,
        OP_NACK  = 3'd7
    } op_t;

    // one tick as decoded by the front end
    typedef struct packed {
        op_t        op;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } cmd_t;

    // pin and status snapshot after one tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } res_t;

endpackage

// ===== rtl/i2cbb_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cbb_fifo
// Small register FIFO; no push when full, no pop when empty.
// ----------------------------------------------------------------------------
module i2cbb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/i2cbb_front.sv =====
// ----------------------------------------------------------------------------
// i2cbb_front
// Input stage: takes one tick per transaction and decodes its opcode.
// ----------------------------------------------------------------------------
module i2cbb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [2:0]        opcode,
    input  logic [7:0]        tx_byte,
    input  logic              send_ack,
    input  logic              sda_in,
    output i2cbb_pkg::cmd_t   cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);

    logic            valid_reg, valid_next;
    i2cbb_pkg::cmd_t cmd_reg;
    i2cbb_pkg::op_t  op_dec;
    logic            take;

    always_comb
    begin
        unique case (opcode)
            3'd1:    op_dec = i2cbb_pkg::OP_START;
            3'd2:    op_dec = i2cbb_pkg::OP_STOP;
            3'd3:    op_dec = i2cbb_pkg::OP_WRITE;
            3'd4:    op_dec = i2cbb_pkg::OP_WAIT;
            3'd5:    op_dec = i2cbb_pkg::OP_READ;
            3'd6:    op_dec = i2cbb_pkg::OP_ACK;
            3'd7:    op_dec = i2cbb_pkg::OP_NACK;
            default: op_dec = i2cbb_pkg::OP_NONE;
        endcase
    end

    assign full      = valid_reg && !cmd_ready;
    assign take      = push && !full;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.op       <= op_dec;
            cmd_reg.tx_byte  <= tx_byte;
            cmd_reg.send_ack <= send_ack;
            cmd_reg.sda_in   <= sda_in;
        end
    end

endmodule

// ===== rtl/i2cbb_back.sv =====
// ----------------------------------------------------------------------------
// i2cbb_back
// Bus sequencer: advances the pin state machine by one tick per command.
// ----------------------------------------------------------------------------
`include "i2c_bitbang_master_sequencer_defines.svh"

module i2cbb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      ack_poll_limit,
    input  logic            cmd_valid,
    input  i2cbb_pkg::cmd_t cmd,
    output logic            cmd_pop,
    input  logic            res_ready,
    output logic            res_valid,
    output i2cbb_pkg::res_t res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_WA_A,
        PH_WA_B,
        PH_WA_P,
        PH_WR_A,
        PH_WR_B,
        PH_WR_C,
        PH_RD_A,
        PH_RD_B,
        PH_AK_A,
        PH_AK_B
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] tick_count_reg, tick_count_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] tx_shift_reg, tx_shift_next;
    logic [7:0] rx_shift_reg, rx_shift_next;
    logic [7:0] poll_count_reg, poll_count_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       drive_reg, drive_next;
    logic       fail_reg, fail_next;
    logic       done;
    logic       step;
    logic       expired;
    logic       poll_now;

    assign step      = cmd_valid && res_ready;
    assign cmd_pop   = step;
    assign res_valid = step;
    assign expired   = (tick_count_reg <= 3'd1);
    assign poll_now  = (phase_reg == PH_WA_P) || ((phase_reg == PH_WA_B) && expired);

    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_count_next  = bit_count_reg;
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        poll_count_next = poll_count_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        drive_next      = drive_reg;
        fail_next       = fail_reg;
        done            = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            unique case (cmd.op)
                i2cbb_pkg::OP_START:
                begin
                    drive_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
                    phase_next = PH_ST_A; tick_count_next = i2cbb_pkg::T_LONG;
                end
                i2cbb_pkg::OP_STOP:
                begin
                    drive_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                    phase_next = PH_SP_A; tick_count_next = i2cbb_pkg::T_LONG;
                end
                i2cbb_pkg::OP_WRITE:
                begin
                    tx_shift_next  = cmd.tx_byte;
                    bit_count_next = '0;
                    drive_next = 1'b1; scl_next = 1'b0; sda_next = cmd.tx_byte[7];
                    phase_next = PH_WR_A; tick_count_next = i2cbb_pkg::T_HALF;
                end
                i2cbb_pkg::OP_WAIT:
                begin
                    fail_next       = 1'b0;
                    poll_count_next = '0;
                    drive_next = 1'b0; sda_next = 1'b1;
                    phase_next = PH_WA_A; tick_count_next = i2cbb_pkg::T_HALF;
                end
                i2cbb_pkg::OP_READ:
                begin
                    ack_choice_next = cmd.send_ack;
                    bit_count_next  = '0;
                    drive_next = 1'b0; scl_next = 1'b0;
                    phase_next = PH_RD_A; tick_count_next = i2cbb_pkg::T_HALF;
                end
                i2cbb_pkg::OP_ACK, i2cbb_pkg::OP_NACK:
                begin
                    scl_next = 1'b0; drive_next = 1'b1;
                    sda_next = (cmd.op == i2cbb_pkg::OP_NACK);
                    phase_next = PH_AK_A; tick_count_next = i2cbb_pkg::T_HALF;
                end
                default:
                begin
                end
            endcase
        end
        else if (poll_now)
        begin
            // ack window: poll SDA every tick
            phase_next      = PH_WA_P;
            tick_count_next = '0;
            if (!cmd.sda_in)
            begin
                scl_next   = 1'b0;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
            else if (poll_count_reg >= ack_poll_limit)
            begin
                fail_next  = 1'b1;
                drive_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                phase_next = PH_SP_A; tick_count_next = i2cbb_pkg::T_LONG;
            end
            else
            begin
                poll_count_next = poll_count_reg + 8'd1;
            end
        end
        else if (expired)
        begin
            unique case (phase_reg)
                PH_ST_A:
                begin
                    sda_next = 1'b0;
                    phase_next = PH_ST_B; tick_count_next = i2cbb_pkg::T_LONG;
                end
                PH_ST_B:
                begin
                    scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                end
                PH_SP_A:
                begin
                    scl_next = 1'b1; sda_next = 1'b1;
                    phase_next = PH_SP_B; tick_count_next = i2cbb_pkg::T_LONG;
                end
                PH_SP_B:
                begin
                    phase_next = PH_IDLE; done = 1'b1;
                end
                PH_WA_A:
                begin
                    scl_next = 1'b1;
                    phase_next = PH_WA_B; tick_count_next = i2cbb_pkg::T_HALF;
                end
                PH_WR_A:
                begin
                    scl_next = 1'b1;
                    phase_next = PH_WR_B; tick_count_next = i2cbb_pkg::T_HALF;
                end
                PH_WR_B:
                begin
                    scl_next = 1'b0;
                    phase_next = PH_WR_C; tick_count_next = i2cbb_pkg::T_HALF;
                end
                PH_WR_C:
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                    if (bit_count_next >= i2cbb_pkg::BITS_PER_BYTE)
                    begin
                        phase_next = PH_IDLE; done = 1'b1;
                    end
                    else
                    begin
                        tx_shift_next = {tx_shift_reg[6:0], 1'b0};
                        sda_next      = tx_shift_reg[6];
                        phase_next = PH_WR_A; tick_count_next = i2cbb_pkg::T_HALF;
                    end
                end
                PH_RD_A:
                begin
                    scl_next      = 1'b1;
                    rx_shift_next = {rx_shift_reg[6:0], cmd.sda_in};
                    phase_next = PH_RD_B; tick_count_next = i2cbb_pkg::T_SAMPLE;
                end
                PH_RD_B:
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                    if (bit_count_next >= i2cbb_pkg::BITS_PER_BYTE)
                    begin
                        // trailing ack/nack bit chosen at read start
                        scl_next = 1'b0; drive_next = 1'b1; sda_next = !ack_choice_reg;
                        phase_next = PH_AK_A; tick_count_next = i2cbb_pkg::T_HALF;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        phase_next = PH_RD_A; tick_count_next = i2cbb_pkg::T_HALF;
                    end
                end
                PH_AK_A:
                begin
                    scl_next = 1'b1;
                    phase_next = PH_AK_B; tick_count_next = i2cbb_pkg::T_HALF;
                end
                PH_AK_B:
                begin
                    scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else
        begin
            tick_count_next = tick_count_reg - 3'd1;
        end
    end

    always_comb
    begin
        res.scl_level  = scl_next;
        res.sda_level  = sda_next;
        res.sda_drive  = drive_next;
        res.busy_res   = (phase_next != PH_IDLE);
        res.done_res   = done;
        res.rx_byte    = rx_shift_next;
        res.ack_failed = fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_count_reg  <= '0;
            tx_shift_reg   <= '0;
            rx_shift_reg   <= '0;
            poll_count_reg <= '0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            drive_reg      <= 1'b1;
            fail_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_count_reg  <= bit_count_next;
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            poll_count_reg <= poll_count_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            drive_reg      <= drive_next;
            fail_reg       <= fail_next;
        end
    end

    // a completing tick always returns the sequencer to idle
    `I2CBB_ASSERT_NEXT(a_done_to_idle, step && done, phase_reg == PH_IDLE)
    // no tick consumed, no state movement
    `I2CBB_ASSERT_NEXT(a_hold_on_stall, !step, $stable(phase_reg) && $stable(rx_shift_reg))
    // during a read the master releases SDA and stays within one byte
    `I2CBB_ASSERT_NOW(a_read_released, (phase_reg == PH_RD_A) || (phase_reg == PH_RD_B),
        !drive_reg && (bit_count_reg < i2cbb_pkg::BITS_PER_BYTE))

endmodule

// ===== rtl/i2c_bitbang_master_sequencer.sv =====
// A tick passes the front-end register, the command queue and the result queue in turn.
// Throughput: one tick per clock while no queue stalls; the sequencer steps once per tick.
// Both sides stall on their own through the command queue and the result queue.
// Reset (rst_n low, asynchronous): queues empty, sequencer idle, SCL/SDA high and driven,
// ack_poll_limit back to 250, ack_failed and rx_byte cleared.
// ----------------------------------------------------------------------------
// i2c_bitbang_master_sequencer
// I2C master bit-level sequencer: one transaction per bus tick, one pin/status
// snapshot per tick out. Front end decodes, a queue decouples, back end steps
// the bus state machine, and a result queue holds snapshots until popped.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,

    // tick input queue
    input  logic        push,
    output logic        full,
    input  logic [2:0]  opcode,
    input  logic [7:0]  tx_byte,
    input  logic        send_ack,
    input  logic        sda_in,

    // result queue
    output logic        empty,
    input  logic        pop,
    output logic        scl_level,
    output logic        sda_level,
    output logic        sda_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  rx_byte,
    output logic        ack_failed,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CMD_W = $bits(i2cbb_pkg::cmd_t);
    localparam int RES_W = $bits(i2cbb_pkg::res_t);

    // register index 0 sits at byte address 0; address bit 2 selects the index
    localparam logic REG_POLL_LIMIT = 1'b0;

    logic [7:0]      limit_reg;
    logic            cfg_wr;

    i2cbb_pkg::cmd_t front_cmd;
    logic            front_valid;
    logic            mid_full;
    logic [CMD_W-1:0] mid_rd_data;
    logic            mid_empty;
    i2cbb_pkg::cmd_t back_cmd;
    logic            back_pop;

    i2cbb_pkg::res_t back_res;
    logic            back_res_valid;
    logic            out_full;
    logic [RES_W-1:0] out_rd_data;
    i2cbb_pkg::res_t out_res;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POLL_LIMIT);
    assign prdata = (paddr[2] == REG_POLL_LIMIT) ? {24'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= i2cbb_pkg::POLL_RESET;
        end
        else if (cfg_wr)
        begin
            limit_reg <= pwdata[7:0];
        end
    end

    // ---------------- front end: accept and decode ----------------
    i2cbb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .tx_byte   (tx_byte),
        .send_ack  (send_ack),
        .sda_in    (sda_in),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (!mid_full)
    );

    // ---------------- command queue ----------------
    i2cbb_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_cmd),
        .full    (mid_full),
        .rd_en   (back_pop),
        .rd_data (mid_rd_data),
        .empty   (mid_empty)
    );

    assign back_cmd = mid_rd_data;

    // ---------------- back end: bus sequencer ----------------
    // steps once per queued tick whenever the result queue has room
    i2cbb_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ack_poll_limit (limit_reg),
        .cmd_valid      (!mid_empty),
        .cmd            (back_cmd),
        .cmd_pop        (back_pop),
        .res_ready      (!out_full),
        .res_valid      (back_res_valid),
        .res            (back_res)
    );

    // ---------------- result queue ----------------
    i2cbb_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_res_valid),
        .wr_data (back_res),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .empty   (empty)
    );

    assign out_res    = out_rd_data;
    assign scl_level  = out_res.scl_level;
    assign sda_level  = out_res.sda_level;
    assign sda_drive  = out_res.sda_drive;
    assign busy_res   = out_res.busy_res;
    assign done_res   = out_res.done_res;
    assign rx_byte    = out_res.rx_byte;
    assign ack_failed = out_res.ack_failed;

endmodule
